FILE: rtl/tetra_pattern_pixel_coder_top_defines.svh
// assertion macros shared by the checker
`ifndef TETRA_PATTERN_PIXEL_CODER_TOP_DEFINES_SVH
`define TETRA_PATTERN_PIXEL_CODER_TOP_DEFINES_SVH

// same-cycle implication, off while reset is low
`define TPP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tpp checker: implication failed");

// next-cycle implication, off while reset is low
`define TPP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tpp checker: next-cycle implication failed");

// next-cycle implication, checked through reset
`define TPP_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("tpp checker: reset behavior failed");

`endif

FILE: rtl/tpp_pkg.sv
package tpp_pkg;

    localparam int PIX_W         = 8;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int Q_DEPTH_DEF   = 4;
    localparam int LINES         = 3;
    localparam int WIN_N         = 16;
    localparam int MODE_W        = 2;
    localparam int WIDTH_W       = 11;
    localparam int HEIGHT_W      = 13;
    localparam int ROW_W         = 12;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 13;
    localparam int MIN_SIZE      = 4;
    localparam int MAX_HEIGHT    = 4096;
    localparam int GRAD_W        = 17;
    localparam int RING_N        = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [MODE_W-1:0] MODE_DIR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MAG  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NBR  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ZERO = 2'd3;

    localparam logic [MODE_W-1:0]   MODE_RST   = MODE_DIR;
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;

    typedef logic [PIX_W-1:0] t_pix;
    typedef t_pix [WIN_N-1:0] t_win;

    typedef struct packed {
        t_win win;
        logic zero;
    } t_job;

    typedef struct packed {
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
    } t_dims;

endpackage

FILE: rtl/tetra_pattern_pixel_coder_top.sv
// channel   | dir | transaction carries
// ----------+-----+---------------------------------------------------
// s_axis    | in  | tdata: pixel[7:0]; tuser: frame_start[0]
// m_axis    | out | tdata: pattern_code[7:0], centre one row up, two left
// i_cfg_*   | in  | write of pattern_mode, image_width or image_height
//
// one pixel per clock while s_axis_tready is high; each result is registered through the
// line-store read, queue, gradient stage and output register
// reset is synchronous, active low; the line store has no clearing pass
// a 4-entry queue between classification and coding absorbs output stalls;
// s_axis_tready drops only when the queue and the item in flight fill it
module tetra_pattern_pixel_coder_top #(
    parameter int MAX_WIDTH   = tpp_pkg::MAX_WIDTH_DEF,
    parameter int QUEUE_DEPTH = tpp_pkg::Q_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // pixel[7:0]
    input  logic [0:0]                      s_axis_tuser,  // frame_start[0]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,  // pattern_code[7:0]
    input  logic                            i_cfg_we,
    input  logic [tpp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tpp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import tpp_pkg::*;

    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    logic [MODE_W-1:0]   r_mode;
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;

    t_dims               dims;
    logic                push;
    t_job                push_job;
    logic                pop;
    logic                q_valid;
    t_job                q_job;
    logic [QC_W-1:0]     q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_RST;
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE:   r_mode   <= i_cfg_data[MODE_W-1:0];
                CFG_WIDTH:  r_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[HEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign dims = '{width: r_width, height: r_height};

    tpp_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .Q_DEPTH   (QUEUE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dims        (dims),
        .i_q_count     (q_count),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_pixel       (s_axis_tdata),
        .i_frame_start (s_axis_tuser[0]),
        .o_push        (push),
        .o_job         (push_job)
    );

    tpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_job),
        .o_count (q_count)
    );

    tpp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mode    (r_mode),
        .i_q_valid (q_valid),
        .i_job     (q_job),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_code    (m_axis_tdata)
    );

endmodule

FILE: rtl/tpp_ram.sv
module tpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/tpp_front.sv
module tpp_front #(
    parameter int MAX_WIDTH = tpp_pkg::MAX_WIDTH_DEF,
    parameter int Q_DEPTH   = tpp_pkg::Q_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tpp_pkg::t_dims                 i_dims,
    input  logic [$clog2(Q_DEPTH+1)-1:0]   i_q_count,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  tpp_pkg::t_pix                  i_pixel,
    input  logic                           i_frame_start,
    output logic                           o_push,
    output tpp_pkg::t_job                  o_job
);

    import tpp_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CNT_W = COL_W + 1;
    localparam int CLW   = (CNT_W > WIDTH_W) ? CNT_W : WIDTH_W;
    localparam int QC_W  = $clog2(Q_DEPTH + 1);
    localparam int RAM_W = LINES * PIX_W;

    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic                r_s1_valid;
    t_pix                r_s1_pix;
    logic [COL_W-1:0]    r_s1_addr;
    logic                r_s1_emit;
    logic                r_s1_zero;
    logic                r_s1_byp;
    logic [RAM_W-1:0]    r_s1_byp_data;
    t_win                r_win;

    logic [CLW-1:0]      w_reg_x;
    logic [CLW-1:0]      w_eff_x;
    logic [CNT_W-1:0]    w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [QC_W:0]       q_used;
    logic                accept;
    logic [CNT_W-1:0]    c0;
    logic [CNT_W-1:0]    c1;
    logic [CNT_W-1:0]    cn;
    logic [HEIGHT_W-1:0] r0;
    logic [HEIGHT_W-1:0] r1;
    logic [HEIGHT_W-1:0] r2;
    logic [HEIGHT_W-1:0] rn;
    logic [COL_W-1:0]    n_col;
    logic [ROW_W-1:0]    n_row;
    logic                emit;
    logic                zero;
    logic [RAM_W-1:0]    ram_rdata;
    logic [RAM_W-1:0]    line_rd;
    logic [RAM_W-1:0]    ram_wdata;
    t_pix [3:0]          column_in;
    t_win                n_win;

    // effective frame size
    always_comb begin
        w_reg_x = CLW'(i_dims.width);
        if (w_reg_x < CLW'(MIN_SIZE)) begin
            w_eff_x = CLW'(MIN_SIZE);
        end else if (w_reg_x > CLW'(MAX_WIDTH)) begin
            w_eff_x = CLW'(MAX_WIDTH);
        end else begin
            w_eff_x = w_reg_x;
        end
        w_eff = w_eff_x[CNT_W-1:0];
        if (i_dims.height < HEIGHT_W'(MIN_SIZE)) begin
            h_eff = HEIGHT_W'(MIN_SIZE);
        end else if (i_dims.height > HEIGHT_W'(MAX_HEIGHT)) begin
            h_eff = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            h_eff = i_dims.height;
        end
    end

    // room for the item in flight and the new one
    assign q_used     = {1'b0, i_q_count} + (QC_W+1)'(r_s1_valid);
    assign o_in_ready = q_used < (QC_W+1)'(Q_DEPTH);
    assign accept     = i_in_valid && o_in_ready;

    // raster position of the arriving pixel and of the next one
    always_comb begin
        c0 = i_frame_start ? '0 : {1'b0, r_col};
        r0 = i_frame_start ? '0 : HEIGHT_W'(r_row);
        if (c0 >= w_eff) begin
            c1 = '0;
            r1 = r0 + HEIGHT_W'(1);
        end else begin
            c1 = c0;
            r1 = r0;
        end
        r2 = (r1 >= h_eff) ? '0 : r1;
        cn = c1 + CNT_W'(1);
        if (cn >= w_eff) begin
            n_col = '0;
            rn    = r2 + HEIGHT_W'(1);
            if (rn >= h_eff) begin
                rn = '0;
            end
        end else begin
            n_col = cn[COL_W-1:0];
            rn    = r2;
        end
        n_row = rn[ROW_W-1:0];
        emit  = (r2 >= HEIGHT_W'(1)) && (c1 >= CNT_W'(2));
        zero  = !((r2 >= HEIGHT_W'(3)) && (c1 >= CNT_W'(4)));
    end

    // line store word: oldest row high, newest row low
    assign line_rd   = r_s1_byp ? r_s1_byp_data : ram_rdata;
    assign ram_wdata = {line_rd[2*PIX_W-1:0], r_s1_pix};

    tpp_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (c1[COL_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        column_in[0] = line_rd[3*PIX_W-1:2*PIX_W];
        column_in[1] = line_rd[2*PIX_W-1:PIX_W];
        column_in[2] = line_rd[PIX_W-1:0];
        column_in[3] = r_s1_pix;
        for (int row = 0; row < 4; row++) begin
            for (int col = 0; col < 3; col++) begin
                n_win[row*4+col] = r_win[row*4+col+1];
            end
            n_win[row*4+3] = column_in[row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_win      <= '0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (r_s1_valid) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix      <= i_pixel;
            r_s1_addr     <= c1[COL_W-1:0];
            r_s1_emit     <= emit;
            r_s1_zero     <= zero;
            // write to the same column in this cycle is not yet in the ram read
            r_s1_byp      <= r_s1_valid && (r_s1_addr == c1[COL_W-1:0]);
            r_s1_byp_data <= ram_wdata;
        end
    end

    assign o_push   = r_s1_valid && r_s1_emit;
    assign o_job    = '{win: n_win, zero: r_s1_zero};

endmodule

FILE: rtl/tpp_queue.sv
module tpp_queue #(
    parameter int DEPTH = tpp_pkg::Q_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  tpp_pkg::t_job                i_data,
    input  logic                         i_pop,
    output logic                         o_valid,
    output tpp_pkg::t_job                o_data,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    import tpp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rp];
    assign o_count = r_count;

endmodule

FILE: rtl/tpp_back.sv
module tpp_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [tpp_pkg::MODE_W-1:0]   i_mode,
    input  logic                         i_q_valid,
    input  tpp_pkg::t_job                i_job,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output tpp_pkg::t_pix                o_code
);

    import tpp_pkg::*;

    // window positions, row-major over rows -2..1 and columns -1..2 of the centre
    localparam int IDX_C = 9;
    localparam int IDX_B = 10;
    localparam int IDX_U = 5;
    localparam int RING_IDX [RING_N] = '{5, 4, 8, 12, 13, 14, 10, 6};
    localparam int H1_IDX [4] = '{7, 11, 15, 14};
    localparam int V1_IDX [4] = '{2, 6, 10, 9};
    localparam int H2_IDX [4] = '{13, 9, 5, 6};
    localparam int V2_IDX [4] = '{8, 4, 0, 1};

    function automatic logic [GRAD_W-1:0] grad_sq(t_pix b, t_pix u, t_pix a);
        logic signed [PIX_W:0]     db;
        logic signed [PIX_W:0]     du;
        logic signed [2*PIX_W+1:0] sb;
        logic signed [2*PIX_W+1:0] su;
        db = $signed({1'b0, b}) - $signed({1'b0, a});
        du = $signed({1'b0, u}) - $signed({1'b0, a});
        sb = db * db;
        su = du * du;
        return GRAD_W'(unsigned'(sb)) + GRAD_W'(unsigned'(su));
    endfunction

    function automatic t_pix dir_code(t_win w);
        t_pix code;
        t_pix dv;
        t_pix dh;
        code = '0;
        for (int k = 0; k < 4; k++) begin
            dv = w[V1_IDX[k]] - w[V2_IDX[k]];
            dh = w[H1_IDX[k]] - w[H2_IDX[k]];
            code[2*k+1] = dv[PIX_W-1];
            code[2*k]   = dv[PIX_W-1] ^ dh[PIX_W-1];
        end
        return code;
    endfunction

    logic                    r_b1_valid;
    logic [GRAD_W-1:0]       r_b1_grad [RING_N+1];
    t_pix                    r_b1_dir;
    logic                    r_b1_zero;
    logic                    r_out_valid;
    t_pix                    r_out_code;

    logic                    b1_take;
    logic                    b2_take;
    t_pix                    code;

    assign b2_take = !r_out_valid || i_ready;
    assign b1_take = !r_b1_valid || b2_take;
    assign o_pop   = i_q_valid && b1_take;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int d = 0; d < RING_N; d++) begin
                r_b1_grad[d] <= grad_sq(i_job.win[IDX_B], i_job.win[IDX_U],
                                        i_job.win[RING_IDX[d]]);
            end
            r_b1_grad[RING_N] <= grad_sq(i_job.win[IDX_B], i_job.win[IDX_U],
                                         i_job.win[IDX_C]);
            r_b1_dir  <= dir_code(i_job.win);
            r_b1_zero <= i_job.zero;
        end
    end

    always_comb begin
        code = '0;
        unique case (i_mode)
            MODE_DIR: begin
                code = r_b1_dir;
            end
            MODE_MAG: begin
                for (int d = 0; d < RING_N; d++) begin
                    code[d] = r_b1_grad[d] >= r_b1_grad[RING_N];
                end
            end
            MODE_NBR: begin
                for (int d = 0; d < RING_N - 1; d++) begin
                    code[d] = r_b1_grad[d] >= r_b1_grad[d+1];
                end
            end
            MODE_ZERO: begin
                code = '0;
            end
            default: begin
                code = '0;
            end
        endcase
        if (r_b1_zero) begin
            code = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (b1_take) begin
                r_b1_valid <= i_q_valid;
            end
            if (b2_take) begin
                r_out_valid <= r_b1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b2_take && r_b1_valid) begin
            r_out_code <= code;
        end
    end

    assign o_valid = r_out_valid;
    assign o_code  = r_out_code;

endmodule

FILE: rtl/tpp_checker.sv
`include "tetra_pattern_pixel_coder_top_defines.svh"

module tpp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [7:0]                      m_axis_tdata
);

    // no result right after reset
    `TPP_ASSERT_NEXT_ALWAYS(a_reset_clears_out, !i_rst_n, !m_axis_tvalid)

    // a stalled result holds
    `TPP_ASSERT_NEXT(a_out_holds, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata))

    // input back-pressure only follows an output stall
    `TPP_ASSERT_IMP(a_ready_after_stall, !s_axis_tready,
                    $past(m_axis_tvalid && !m_axis_tready))

endmodule

bind tetra_pattern_pixel_coder_top tpp_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
